FILE: hdl/ntp_avg_pkg.sv
// Shared types, codes and constants for the NTP offset / round-trip averager.
// This package has no dependencies. Every module in hdl/ imports it.
package ntp_avg_pkg;

    // Field widths.
    localparam int unsigned NS_W      = 30;   // bits of the nanosecond part
    localparam int unsigned SEC_W     = 32;   // bits of the seconds part
    localparam int unsigned TIME_W    = 64;   // bits of a time in nanoseconds
    localparam int unsigned S_DATA_W  = 256;  // width of the input tdata
    localparam int unsigned M_DATA_W  = 272;  // width of the output tdata
    localparam int unsigned MAX_SAMPLES_DEF = 255;

    // Nanoseconds per second. The multiplier bits are walked LSB first.
    localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

    // Command codes, carried in s_tuser.
    localparam logic [1:0] CMD_REQ = 2'd0;
    localparam logic [1:0] CMD_RSP = 2'd1;
    localparam logic [1:0] CMD_CLR = 2'd2;

    // Status codes, carried in m_tuser.
    localparam logic [2:0] STAT_REQ = 3'd0;
    localparam logic [2:0] STAT_CLR = 3'd1;
    localparam logic [2:0] STAT_ACC = 3'd2;
    localparam logic [2:0] STAT_IGN = 3'd3;
    localparam logic [2:0] STAT_MIS = 3'd4;

    // Sync phase codes.
    localparam logic [1:0] PH_UNSYNC  = 2'd0;
    localparam logic [1:0] PH_SYNCING = 2'd1;
    localparam logic [1:0] PH_SYNCED  = 2'd2;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CONV = 6'b000010,
        ST_DIFF = 6'b000100,
        ST_SUM  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

endpackage

FILE: hdl/ntp_avg_tons.sv
// Bit-serial conversion of seconds plus nanoseconds to nanoseconds.
// Walks the 30 bits of one billion LSB first, one shift-add per cycle. Uses ntp_avg_pkg.
module ntp_avg_tons (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [ntp_avg_pkg::SEC_W-1:0]     sec,
    input  logic [ntp_avg_pkg::NS_W-1:0]      nsec,
    output logic                              done,
    output logic [ntp_avg_pkg::TIME_W-1:0]    ns
);
    import ntp_avg_pkg::*;

    localparam int unsigned CNT_W = $clog2(NS_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [NS_W-1:0]      mult_reg;
    logic [TIME_W-1:0]    mcand_reg;
    logic [TIME_W-1:0]    acc_reg;

    // Control: busy while the multiplier bits are walked, then a one-cycle done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NS_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: one conditional add of the shifted seconds per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg <= {{(TIME_W-SEC_W){sec[SEC_W-1]}}, sec};
            mult_reg  <= NS_PER_SEC;
            acc_reg   <= {{(TIME_W-NS_W){1'b0}}, nsec};
        end else if (busy_reg) begin
            if (mult_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg <= {mcand_reg[TIME_W-2:0], 1'b0};
            mult_reg  <= {1'b0, mult_reg[NS_W-1:1]};
        end
    end

    assign done = done_reg;
    assign ns   = acc_reg;

endmodule

FILE: hdl/ntp_avg_div.sv
// Radix-2 restoring divider: signed 64-bit dividend by unsigned count, truncating.
// One quotient bit per cycle, then a fix-up step applies the sign. Uses ntp_avg_pkg.
module ntp_avg_div #(
    parameter int unsigned CNT_W = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [ntp_avg_pkg::TIME_W-1:0]    dividend,
    input  logic [CNT_W-1:0]                  divisor,
    output logic                              done,
    output logic [ntp_avg_pkg::TIME_W-1:0]    quotient
);
    import ntp_avg_pkg::*;

    localparam int unsigned IDX_W = $clog2(TIME_W);

    logic                 busy_reg;
    logic                 fix_reg;
    logic                 done_reg;
    logic [IDX_W-1:0]     cnt_reg;
    logic                 neg_reg;
    logic [CNT_W-1:0]     dsr_reg;
    logic [TIME_W-1:0]    dvd_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [TIME_W-1:0]    q_reg;
    logic [CNT_W:0]       trial;
    logic                 fits;

    // Trial subtract of the divisor from the partial remainder
    assign trial = {rem_reg, dvd_reg[TIME_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    // Control: one step per dividend bit, a sign fix-up, a done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= fix_reg;
            fix_reg  <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(TIME_W - 1)) begin
                    busy_reg <= 1'b0;
                    fix_reg  <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend magnitude shifts out, quotient bits shift in
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[TIME_W-1];
            dvd_reg <= dividend[TIME_W-1] ? (~dividend + 1'b1) : dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? CNT_W'(trial - {1'b0, dsr_reg}) : CNT_W'(trial);
            dvd_reg <= {dvd_reg[TIME_W-2:0], fits};
        end
        if (fix_reg) begin
            q_reg <= neg_reg ? (~dvd_reg + 1'b1) : dvd_reg;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: hdl/ntp_offset_rtt_averager.sv
// NTP clock offset / round-trip delay averager, top level.
// Throughput: one word at a time; the next word is taken once the sequencer is idle,
// even while the previous result waits on m_tready. Uses ntp_avg_pkg.
// Reset: aresetn synchronous active low; phase, times, means and count go to zero.
module ntp_offset_rtt_averager #(
    parameter int unsigned MAX_SAMPLES = ntp_avg_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tdata: token[63:0], local_sec[95:64], local_nsec[125:96],
    // remote_recv_sec[157:126], remote_recv_nsec[187:158],
    // remote_send_sec[219:188], remote_send_nsec[249:220], zero pad
    input  logic [ntp_avg_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic [1:0]                          s_tuser,    // command[1:0]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: sync_phase[1:0], clk_offset[65:2], round_trip_ns[129:66],
    // mean_clk_offset[193:130], mean_round_trip_ns[257:194],
    // samples_used[265:258], zero pad
    output logic [ntp_avg_pkg::M_DATA_W-1:0]    m_tdata,
    output logic [2:0]                          m_tuser,    // status[2:0]
    output logic                                m_tvalid,
    input  logic                                m_tready
);
    import ntp_avg_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);

    // Input field unpacking
    logic [63:0]        in_token;
    logic [SEC_W-1:0]   in_lsec, in_rrsec, in_rssec;
    logic [NS_W-1:0]    in_lnsec, in_rrnsec, in_rsnsec;

    assign in_token  = s_tdata[63:0];
    assign in_lsec   = s_tdata[95:64];
    assign in_lnsec  = s_tdata[125:96];
    assign in_rrsec  = s_tdata[157:126];
    assign in_rrnsec = s_tdata[187:158];
    assign in_rssec  = s_tdata[219:188];
    assign in_rsnsec = s_tdata[249:220];

    state_t             state_reg;
    logic               req_reg;
    logic [1:0]         phase_reg;
    logic [2:0]         status_reg;
    logic [63:0]        pend_token_reg;
    logic [TIME_W-1:0]  req_time_reg;
    logic [TIME_W-1:0]  offset_reg, rtt_reg;
    logic [TIME_W-1:0]  avg_off_reg, avg_rtt_reg;
    logic [CNT_W-1:0]   hit_reg;
    logic [TIME_W-1:0]  d10_reg, d23_reg, d30_reg, d21_reg;
    logic               div_start_reg;
    logic               m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [2:0]         m_tuser_reg;

    logic               accept;
    logic               conv_start;
    logic               conv_done, conv_done1, conv_done2;
    logic [TIME_W-1:0]  t1_ns, t2_ns, t3_ns;
    logic               div_done, div_done1, div_done2, div_done3;
    logic [TIME_W-1:0]  q_xo, q_ao, q_xr, q_ar;
    logic [TIME_W-1:0]  off_sum;
    logic               out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // A request or a matching response starts the serial conversions
    assign conv_start = accept && ((s_tuser == CMD_REQ) ||
                        ((s_tuser == CMD_RSP) && (phase_reg == PH_SYNCING) &&
                         (in_token == pend_token_reg)));

    // t3 (or t0 for a request) and the two remote times, converted in parallel
    ntp_avg_tons u_tons_loc (
        .aclk(aclk), .aresetn(aresetn), .start(conv_start),
        .sec(in_lsec), .nsec(in_lnsec), .done(conv_done), .ns(t3_ns)
    );
    ntp_avg_tons u_tons_rr (
        .aclk(aclk), .aresetn(aresetn), .start(conv_start),
        .sec(in_rrsec), .nsec(in_rrnsec), .done(conv_done1), .ns(t1_ns)
    );
    ntp_avg_tons u_tons_rs (
        .aclk(aclk), .aresetn(aresetn), .start(conv_start),
        .sec(in_rssec), .nsec(in_rsnsec), .done(conv_done2), .ns(t2_ns)
    );

    // Four dividers for x/n and avg/n of both means
    ntp_avg_div #(.CNT_W(CNT_W)) u_div_xo (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .dividend(offset_reg), .divisor(hit_reg), .done(div_done), .quotient(q_xo)
    );
    ntp_avg_div #(.CNT_W(CNT_W)) u_div_ao (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .dividend(avg_off_reg), .divisor(hit_reg), .done(div_done1), .quotient(q_ao)
    );
    ntp_avg_div #(.CNT_W(CNT_W)) u_div_xr (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .dividend(rtt_reg), .divisor(hit_reg), .done(div_done2), .quotient(q_xr)
    );
    ntp_avg_div #(.CNT_W(CNT_W)) u_div_ar (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .dividend(avg_rtt_reg), .divisor(hit_reg), .done(div_done3), .quotient(q_ar)
    );

    // Offset sum before the halving toward zero
    assign off_sum = d10_reg + d23_reg;

    // Sequencer and state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            req_reg        <= 1'b0;
            phase_reg      <= PH_UNSYNC;
            status_reg     <= STAT_IGN;
            pend_token_reg <= '0;
            req_time_reg   <= '0;
            offset_reg     <= '0;
            rtt_reg        <= '0;
            avg_off_reg    <= '0;
            avg_rtt_reg    <= '0;
            hit_reg        <= '0;
            div_start_reg  <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (conv_start) begin
                            req_reg   <= (s_tuser == CMD_REQ);
                            state_reg <= ST_CONV;
                            if (s_tuser == CMD_REQ) begin
                                pend_token_reg <= in_token;
                            end
                        end else if (s_tuser == CMD_CLR) begin
                            avg_off_reg <= '0;
                            avg_rtt_reg <= '0;
                            hit_reg     <= '0;
                            status_reg  <= STAT_CLR;
                            state_reg   <= ST_OUT;
                        end else begin
                            status_reg <= ((s_tuser == CMD_RSP) &&
                                           (phase_reg == PH_SYNCING)) ? STAT_MIS : STAT_IGN;
                            state_reg  <= ST_OUT;
                        end
                    end
                end
                ST_CONV: begin
                    if (conv_done) begin
                        if (req_reg) begin
                            req_time_reg <= t3_ns;
                            phase_reg    <= PH_SYNCING;
                            status_reg   <= STAT_REQ;
                            state_reg    <= ST_OUT;
                        end else begin
                            state_reg <= ST_DIFF;
                        end
                    end
                end
                ST_DIFF: begin
                    d10_reg   <= t1_ns - req_time_reg;
                    d23_reg   <= t2_ns - t3_ns;
                    d30_reg   <= t3_ns - req_time_reg;
                    d21_reg   <= t2_ns - t1_ns;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    offset_reg <= $signed(off_sum + {{(TIME_W-1){1'b0}}, off_sum[TIME_W-1]})
                                  >>> 1;
                    rtt_reg    <= d30_reg - d21_reg;
                    if (hit_reg < CNT_W'(MAX_SAMPLES)) begin
                        hit_reg <= hit_reg + 1'b1;
                    end
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        avg_off_reg <= avg_off_reg + (q_xo - q_ao);
                        avg_rtt_reg <= avg_rtt_reg + (q_xr - q_ar);
                        phase_reg   <= PH_SYNCED;
                        status_reg  <= STAT_ACC;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Output register, holds a finished word until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tuser_reg <= status_reg;
            m_tdata_reg <= {6'd0, 8'(hit_reg), avg_rtt_reg, avg_off_reg,
                            rtt_reg, offset_reg, phase_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks
    a_phase_code: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("phase register holds an unused code");

    a_hit_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_reg <= CNT_W'(MAX_SAMPLES))
        else $error("hit count past saturation");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == CMD_CLR) |=> (hit_reg == '0 && avg_off_reg == '0))
        else $error("clear did not zero the means");

    a_parallel_units: assert property (@(posedge aclk) disable iff (!aresetn)
        (conv_done == conv_done1) && (conv_done == conv_done2) &&
        (div_done == div_done1) && (div_done == div_done2) && (div_done == div_done3))
        else $error("serial units out of step");

endmodule
